// ===== src/l2lch_pkg.sv =====
// ----------------------------------------------------------------------------
// l2lch_pkg
// Types, widths and constants shared by the Lab to LCh polar conversion core.
// ----------------------------------------------------------------------------
package l2lch_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned ATAN_ENTRIES     = 24;
	localparam int unsigned GUARD            = 16;

	// datapath widths
	localparam int unsigned XW  = 35;
	localparam int unsigned ZW  = 30;
	localparam int unsigned HW  = ZW - 12;
	localparam int unsigned XMW = XW - 1;
	localparam int unsigned XLW = XMW / 2;
	localparam int unsigned XHW = XMW - XLW;
	localparam int unsigned GW  = 30;
	localparam int unsigned MLW = XLW + GW;
	localparam int unsigned MHW = XHW + GW;
	localparam int unsigned SW  = 64;
	localparam int unsigned RSH = 46;

	localparam logic signed [ZW-1:0] DEG180     = ZW'(94371840);
	localparam logic signed [ZW-1:0] HUE_RND    = ZW'(2048);
	localparam logic signed [HW-1:0] HUE_FULL   = HW'(46080);
	localparam logic [SW-RSH-1:0]    CHROMA_MAX = (SW-RSH)'(46341);
	localparam logic [GW-1:0]        INV_GAIN   = GW'(652032874);
	localparam logic [SW-1:0]        MAG_RND    = SW'(1) << (RSH - 1);

	localparam logic [24:0] ATAN_TAB [ATAN_ENTRIES] = '{
		25'd23592960, 25'd13927738, 25'd7359034, 25'd3735561,
		25'd1875029,  25'd938429,   25'd469329,  25'd234679,
		25'd117341,   25'd58671,    25'd29335,   25'd14668,
		25'd7334,     25'd3667,     25'd1833,    25'd917,
		25'd458,      25'd229,      25'd115,     25'd57,
		25'd29,       25'd14,       25'd7,       25'd4
	};

	typedef struct packed {
		logic [15:0]        light_in;
		logic signed [15:0] a_in;
		logic signed [15:0] b_in;
	} lab_t;

	typedef struct packed {
		logic [15:0] light_out;
		logic [15:0] chroma;
		logic [15:0] hue;
	} lch_t;

	typedef struct packed {
		logic [15:0]          light;
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [15:0]    light;
		logic           zero;
		logic [MLW-1:0] plo;
		logic [MHW-1:0] phi;
		logic [15:0]    hue;
	} mul_t;

endpackage

// ===== src/l2lch_if.sv =====
// ----------------------------------------------------------------------------
// l2lch_if
// Valid/ready stream channel carrying one beat of payload.
// ----------------------------------------------------------------------------
interface l2lch_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/l2lch_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// l2lch_cordic_stage
// One registered CORDIC vectoring micro-rotation with its own valid bit.
// ----------------------------------------------------------------------------
module l2lch_cordic_stage #(
	parameter int unsigned IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  l2lch_pkg::cordic_t up_data,
	output logic              up_ready,
	output logic              dn_valid,
	output l2lch_pkg::cordic_t dn_data,
	input  logic              dn_ready
);
	import l2lch_pkg::*;

	localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[IDX]);

	logic    v_s1;
	cordic_t d_s1;
	cordic_t nxt;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = up_data.y >>> IDX;
	assign dy = up_data.x >>> IDX;

	always_comb begin
		nxt = up_data;
		if (!up_data.y[XW-1]) begin
			nxt.x = up_data.x + dx;
			nxt.y = up_data.y - dy;
			nxt.z = up_data.z + ANG;
		end else begin
			nxt.x = up_data.x - dx;
			nxt.y = up_data.y + dy;
			nxt.z = up_data.z - ANG;
		end
	end

	assign up_ready = !v_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			d_s1 <= nxt;
		end
	end

	assign dn_valid = v_s1;
	assign dn_data  = d_s1;

endmodule

// ===== src/lab_to_lch_polar_conversion_core.sv =====
// ----------------------------------------------------------------------------
// lab_to_lch_polar_conversion_core
// Lab to LCh conversion: chroma and hue from an unrolled CORDIC pipeline.
// ----------------------------------------------------------------------------
// usage:
//   lab carries one pixel per beat (light_in, a_in, b_in, Q8.8); lch returns
//   one beat per pixel (light_out, chroma Q8.8, hue in 1/128 degree) in
//   the same order.
//   the pipeline is a pre-rotation stage, CORDIC_STEPS micro-rotation
//   stages (at most ATAN_ENTRIES), a gain multiply stage and an output
//   register, which a pixel passes in that order on its way from lab to lch.
//   one pixel per cycle is sustained while lch is ready; the gain product
//   is split into two 17 x 30 partial products summed in the output stage.
//   every stage has its own valid bit and takes a new beat when it is empty
//   or its contents move on, so bubbles close up and lab keeps accepting
//   while lch is stalled until every stage holds a pixel.
//   reset clears all valid bits; nothing is lost or repeated under stalls.
// ----------------------------------------------------------------------------
module lab_to_lch_polar_conversion_core #(
	parameter int unsigned CORDIC_STEPS = l2lch_pkg::CORDIC_STEPS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	l2lch_if.sink   lab,
	l2lch_if.source lch
);
	import l2lch_pkg::*;

	localparam int unsigned ITERS =
		(CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	// pre-rotation stage
	logic    prep_v_s1;
	cordic_t prep_s1;
	cordic_t prep_d;
	logic    prep_rdy;
	logic signed [XW-1:0] a_x;
	logic signed [XW-1:0] b_x;

	// cordic chain
	logic    cv   [ITERS+1];
	cordic_t cd   [ITERS+1];
	logic    crdy [ITERS+1];

	// gain multiply and hue rounding stage
	logic    mul_v_s2;
	mul_t    mul_s2;
	mul_t    mul_d;
	logic    mul_rdy;
	logic [XMW-1:0]       xmag;
	logic signed [ZW-1:0] z_r;
	logic signed [HW-1:0] h0;
	logic signed [HW-1:0] h1;
	logic signed [HW-1:0] h2;

	// output stage
	logic    out_v_s3;
	lch_t    out_s3;
	lch_t    out_d;
	logic    out_rdy;
	logic [SW-1:0]     sum;
	logic [SW-RSH-1:0] mag;

	assign a_x = XW'(lab.data.a_in) <<< GUARD;
	assign b_x = XW'(lab.data.b_in) <<< GUARD;

	always_comb begin
		prep_d.light = lab.data.light_in;
		prep_d.zero  = (lab.data.a_in == '0) && (lab.data.b_in == '0);
		if (lab.data.a_in[15]) begin
			prep_d.x = -a_x;
			prep_d.y = -b_x;
			prep_d.z = DEG180;
		end else begin
			prep_d.x = a_x;
			prep_d.y = b_x;
			prep_d.z = '0;
		end
	end

	assign prep_rdy  = !prep_v_s1 || crdy[0];
	assign lab.ready = prep_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_s1 <= 1'b0;
		end else if (prep_rdy) begin
			prep_v_s1 <= lab.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prep_rdy && lab.valid) begin
			prep_s1 <= prep_d;
		end
	end

	assign cv[0] = prep_v_s1;
	assign cd[0] = prep_s1;

	for (genvar k = 0; k < ITERS; k++) begin : g_iter
		l2lch_cordic_stage #(
			.IDX(k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cv[k]),
			.up_data  (cd[k]),
			.up_ready (crdy[k]),
			.dn_valid (cv[k+1]),
			.dn_data  (cd[k+1]),
			.dn_ready (crdy[k+1])
		);
	end

	assign crdy[ITERS] = mul_rdy;

	assign xmag = cd[ITERS].x[XW-1] ? '0 : cd[ITERS].x[XMW-1:0];
	assign z_r  = cd[ITERS].z + HUE_RND;
	assign h0   = z_r[ZW-1:12];
	assign h1   = h0[HW-1] ? h0 + HUE_FULL : h0;
	assign h2   = (h1 >= HUE_FULL) ? h1 - HUE_FULL : h1;

	always_comb begin
		mul_d.light = cd[ITERS].light;
		mul_d.zero  = cd[ITERS].zero;
		mul_d.plo   = MLW'(xmag[XLW-1:0]) * MLW'(INV_GAIN);
		mul_d.phi   = MHW'(xmag[XMW-1:XLW]) * MHW'(INV_GAIN);
		if (h2[HW-1] || h2 >= HUE_FULL) begin
			mul_d.hue = '0;
		end else begin
			mul_d.hue = h2[15:0];
		end
	end

	assign mul_rdy = !mul_v_s2 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
		end else if (mul_rdy) begin
			mul_v_s2 <= cv[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (mul_rdy && cv[ITERS]) begin
			mul_s2 <= mul_d;
		end
	end

	assign sum = SW'(mul_s2.plo) + (SW'(mul_s2.phi) << XLW) + MAG_RND;
	assign mag = sum[SW-1:RSH];

	always_comb begin
		out_d.light_out = mul_s2.light;
		if (mul_s2.zero) begin
			out_d.chroma = '0;
			out_d.hue    = '0;
		end else begin
			out_d.chroma = (mag > CHROMA_MAX) ? CHROMA_MAX[15:0] : mag[15:0];
			out_d.hue    = mul_s2.hue;
		end
	end

	assign out_rdy = !out_v_s3 || lch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s3 <= 1'b0;
		end else if (out_rdy) begin
			out_v_s3 <= mul_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && mul_v_s2) begin
			out_s3 <= out_d;
		end
	end

	assign lch.valid = out_v_s3;
	assign lch.data  = out_s3;

endmodule

// ===== src/l2lch_check.sv =====
// ----------------------------------------------------------------------------
// l2lch_check
// Port-level checks of the conversion core, bound to its top level.
// ----------------------------------------------------------------------------
module l2lch_check (
	input logic        clk,
	input logic        arst_n,
	input logic        lch_valid,
	input logic        lch_ready,
	input logic [15:0] lch_light,
	input logic [15:0] lch_chroma,
	input logic [15:0] lch_hue
);
	import l2lch_pkg::*;

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		lch_valid && !lch_ready |=> lch_valid && $stable(lch_light) &&
		$stable(lch_chroma) && $stable(lch_hue))
		else $error("lch beat changed while stalled");

	// a clock edge that samples reset asserted is followed by no beat
	a_rst: assert property (@(posedge clk) !arst_n |=> !lch_valid)
		else $error("lch valid during reset");

	// hue wrapped below a full turn
	a_hue: assert property (@(posedge clk) disable iff (!arst_n)
		lch_valid |-> lch_hue < 16'(HUE_FULL))
		else $error("hue out of range");

	// chroma saturated
	a_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		lch_valid |-> lch_chroma <= CHROMA_MAX[15:0])
		else $error("chroma above saturation");

endmodule

bind lab_to_lch_polar_conversion_core l2lch_check u_l2lch_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.lch_valid  (lch.valid),
	.lch_ready  (lch.ready),
	.lch_light  (lch.data.light_out),
	.lch_chroma (lch.data.chroma),
	.lch_hue    (lch.data.hue)
);
